@@ design/hsv2rgb_pkg.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared widths, pipeline payload types, sector codes and the divide by the
// all-ones channel code for the HSV to RGB converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

    localparam int HUE_BITS     = 16;
    localparam int CHANNEL_BITS = 8;
    localparam int PROD_BITS    = HUE_BITS + CHANNEL_BITS;
    localparam int NUM_BITS     = 2 * CHANNEL_BITS;

    typedef logic [HUE_BITS-1:0]     hue_t;
    typedef logic [CHANNEL_BITS-1:0] chan_t;
    typedef logic [PROD_BITS-1:0]    prod_t;
    typedef logic [NUM_BITS-1:0]     num_t;
    typedef logic [2:0]              sector_t;

    // all-ones code means 1.0
    localparam chan_t CH_MAX = '1;
    // one full turn of hue, needs one bit above the hue field
    localparam logic [HUE_BITS:0] HUE_ONE = {1'b1, {HUE_BITS{1'b0}}};
    // 1.0 * 1.0 in the s*f product format
    localparam prod_t FULL_SCALE = {CH_MAX, {HUE_BITS{1'b0}}};

    // colour wheel sectors, 60 degrees each
    localparam sector_t SEC_RY = 3'd0;
    localparam sector_t SEC_YG = 3'd1;
    localparam sector_t SEC_GC = 3'd2;
    localparam sector_t SEC_CB = 3'd3;
    localparam sector_t SEC_BM = 3'd4;
    localparam sector_t SEC_MR = 3'd5;

    typedef struct packed {
        sector_t sector;
        hue_t    frac;
        chan_t   sat;
        chan_t   val;
    } sector_stage_t;

    typedef struct packed {
        sector_t sector;
        chan_t   val;
        chan_t   sat_inv;
        prod_t   q_sub;
        prod_t   t_sub;
    } weight_stage_t;

    typedef struct packed {
        sector_t sector;
        chan_t   val;
        num_t    p_num;
        num_t    q_num;
        num_t    t_num;
    } scale_stage_t;

    // floor(x / CH_MAX) for x <= CH_MAX * CH_MAX
    function automatic chan_t div_by_max(input num_t x);
        num_t sum;
        sum = x + (x >> CHANNEL_BITS) + {{(NUM_BITS-1){1'b0}}, 1'b1};
        return sum[NUM_BITS-1:CHANNEL_BITS];
    endfunction

endpackage

`default_nettype wire

@@ design/hsv2rgb_hsv_if.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_hsv_if
// Valid/ready channel carrying one HSV pixel item.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsv2rgb_hsv_if;
    import hsv2rgb_pkg::*;

    logic  valid;
    logic  ready;
    hue_t  hue_turn;
    chan_t saturation;
    chan_t brightness;

    modport source (output valid, output hue_turn, output saturation,
                    output brightness, input ready);
    modport sink   (input valid, input hue_turn, input saturation,
                    input brightness, output ready);
endinterface

`default_nettype wire

@@ design/hsv2rgb_rgb_if.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_rgb_if
// Valid/ready channel carrying one RGB pixel item.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsv2rgb_rgb_if;
    import hsv2rgb_pkg::*;

    logic  valid;
    logic  ready;
    chan_t red;
    chan_t green;
    chan_t blue;

    modport source (output valid, output red, output green, output blue,
                    input ready);
    modport sink   (input valid, input red, input green, input blue,
                    output ready);
endinterface

`default_nettype wire

@@ design/hsv2rgb_sector.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_sector
// Stage 1: hue times six, split into sector and 16-bit fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_sector (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    hsv2rgb_hsv_if.sink                     hsv_in,
    output logic                            dn_valid,
    input  wire logic                       dn_ready,
    output hsv2rgb_pkg::sector_stage_t      dn_data
);
    import hsv2rgb_pkg::*;

    logic                  valid_reg;
    sector_stage_t         data_reg;
    sector_stage_t         data_next;
    logic [HUE_BITS+2:0]   scaled;
    logic                  load;

    assign hsv_in.ready = ~valid_reg | dn_ready;
    assign load         = hsv_in.valid & hsv_in.ready;

    always_comb
    begin
        // h*6 = h*4 + h*2
        scaled = {1'b0, hsv_in.hue_turn, 2'b00} + {2'b00, hsv_in.hue_turn, 1'b0};
        data_next.sector = scaled[HUE_BITS+2:HUE_BITS];
        data_next.frac   = scaled[HUE_BITS-1:0];
        data_next.sat    = hsv_in.saturation;
        data_next.val    = hsv_in.brightness;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (hsv_in.ready)
            valid_reg <= hsv_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

`default_nettype wire

@@ design/hsv2rgb_weight.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_weight
// Stage 2: saturation weights 1-s, 1-s*f and 1-s*(1-f).
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_weight (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       up_valid,
    output logic                            up_ready,
    input  wire hsv2rgb_pkg::sector_stage_t up_data,
    output logic                            dn_valid,
    input  wire logic                       dn_ready,
    output hsv2rgb_pkg::weight_stage_t      dn_data
);
    import hsv2rgb_pkg::*;

    logic               valid_reg;
    weight_stage_t      data_reg;
    weight_stage_t      data_next;
    logic [HUE_BITS:0]  frac_comp;
    prod_t              sf_prod;
    prod_t              st_prod;
    logic               load;

    assign up_ready = ~valid_reg | dn_ready;
    assign load     = up_valid & up_ready;

    always_comb
    begin
        frac_comp = HUE_ONE - {1'b0, up_data.frac};
        sf_prod   = {{HUE_BITS{1'b0}}, up_data.sat} * {{CHANNEL_BITS{1'b0}}, up_data.frac};
        // s*(1-f) never exceeds 1.0, so the product format holds it
        st_prod   = {{HUE_BITS{1'b0}}, up_data.sat}
                  * {{(CHANNEL_BITS-1){1'b0}}, frac_comp};
        data_next.sector  = up_data.sector;
        data_next.val     = up_data.val;
        data_next.sat_inv = CH_MAX - up_data.sat;
        data_next.q_sub   = FULL_SCALE - sf_prod;
        data_next.t_sub   = FULL_SCALE - st_prod;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

`default_nettype wire

@@ design/hsv2rgb_scale.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_scale
// Stage 3: weights times value; q and t drop the hue fraction bits here.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_scale (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       up_valid,
    output logic                            up_ready,
    input  wire hsv2rgb_pkg::weight_stage_t up_data,
    output logic                            dn_valid,
    input  wire logic                       dn_ready,
    output hsv2rgb_pkg::scale_stage_t       dn_data
);
    import hsv2rgb_pkg::*;

    logic                          valid_reg;
    scale_stage_t                  data_reg;
    scale_stage_t                  data_next;
    logic [NUM_BITS+HUE_BITS-1:0]  q_full;
    logic [NUM_BITS+HUE_BITS-1:0]  t_full;
    logic                          load;

    assign up_ready = ~valid_reg | dn_ready;
    assign load     = up_valid & up_ready;

    always_comb
    begin
        q_full = {{PROD_BITS{1'b0}}, up_data.val} * {{CHANNEL_BITS{1'b0}}, up_data.q_sub};
        t_full = {{PROD_BITS{1'b0}}, up_data.val} * {{CHANNEL_BITS{1'b0}}, up_data.t_sub};
        data_next.sector = up_data.sector;
        data_next.val    = up_data.val;
        data_next.p_num  = {{CHANNEL_BITS{1'b0}}, up_data.val}
                         * {{CHANNEL_BITS{1'b0}}, up_data.sat_inv};
        // floor by the hue scale now, by CH_MAX in the next stage
        data_next.q_num  = q_full[NUM_BITS+HUE_BITS-1:HUE_BITS];
        data_next.t_num  = t_full[NUM_BITS+HUE_BITS-1:HUE_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

`default_nettype wire

@@ design/hsv2rgb_mix.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_mix
// Stage 4: divide by the all-ones code, permute by sector, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_mix (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       up_valid,
    output logic                            up_ready,
    input  wire hsv2rgb_pkg::scale_stage_t  up_data,
    hsv2rgb_rgb_if.source                   rgb_out
);
    import hsv2rgb_pkg::*;

    logic   valid_reg;
    chan_t  red_reg;
    chan_t  green_reg;
    chan_t  blue_reg;
    chan_t  red_next;
    chan_t  green_next;
    chan_t  blue_next;
    chan_t  p_val;
    chan_t  q_val;
    chan_t  t_val;
    chan_t  v_val;
    logic   load;

    assign up_ready = ~valid_reg | rgb_out.ready;
    assign load     = up_valid & up_ready;

    // zero saturation needs no special arm: p, q and t all come out as v
    always_comb
    begin
        p_val = div_by_max(up_data.p_num);
        q_val = div_by_max(up_data.q_num);
        t_val = div_by_max(up_data.t_num);
        v_val = up_data.val;
        unique case (up_data.sector)
            SEC_RY:
            begin
                red_next = v_val; green_next = t_val; blue_next = p_val;
            end
            SEC_YG:
            begin
                red_next = q_val; green_next = v_val; blue_next = p_val;
            end
            SEC_GC:
            begin
                red_next = p_val; green_next = v_val; blue_next = t_val;
            end
            SEC_CB:
            begin
                red_next = p_val; green_next = q_val; blue_next = v_val;
            end
            SEC_BM:
            begin
                red_next = t_val; green_next = p_val; blue_next = v_val;
            end
            SEC_MR:
            begin
                red_next = v_val; green_next = p_val; blue_next = q_val;
            end
            default:
            begin
                red_next = v_val; green_next = p_val; blue_next = q_val;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign rgb_out.valid = valid_reg;
    assign rgb_out.red   = red_reg;
    assign rgb_out.green = green_reg;
    assign rgb_out.blue  = blue_reg;

endmodule

`default_nettype wire

@@ design/hsv_to_rgb_converter_core.sv @@
// Pipeline: four register stages (sector, weight, scale, mix); an accepted
// HSV item shows on the output once it has passed through all of them.
// Throughput: one item per cycle unless the output stalls; each stage is a
// register slot with its own valid bit, so bubbles close up during a stall.
// Reset: asynchronous, active low; clears the valid bits only, the pipeline
// comes out of reset empty and ready.
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core
// HSV to RGB pixel converter: sector split, weights, scale, mix.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    hsv2rgb_hsv_if.sink     hsv_in,
    hsv2rgb_rgb_if.source   rgb_out
);
    import hsv2rgb_pkg::*;

    logic           s1_valid;
    logic           s1_ready;
    sector_stage_t  s1_data;
    logic           s2_valid;
    logic           s2_ready;
    weight_stage_t  s2_data;
    logic           s3_valid;
    logic           s3_ready;
    scale_stage_t   s3_data;

    hsv2rgb_sector u_sector (
        .clk      (clk),
        .rst_n    (rst_n),
        .hsv_in   (hsv_in),
        .dn_valid (s1_valid),
        .dn_ready (s1_ready),
        .dn_data  (s1_data)
    );

    hsv2rgb_weight u_weight (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_ready (s1_ready),
        .up_data  (s1_data),
        .dn_valid (s2_valid),
        .dn_ready (s2_ready),
        .dn_data  (s2_data)
    );

    hsv2rgb_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s2_valid),
        .up_ready (s2_ready),
        .up_data  (s2_data),
        .dn_valid (s3_valid),
        .dn_ready (s3_ready),
        .dn_data  (s3_data)
    );

    hsv2rgb_mix u_mix (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s3_valid),
        .up_ready (s3_ready),
        .up_data  (s3_data),
        .rgb_out  (rgb_out)
    );

endmodule

`default_nettype wire

@@ design/hsv2rgb_checker.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_checker
// Port-level checks on the converter: item occupancy and output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_checker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic                       in_ready,
    input  wire logic                       out_valid,
    input  wire logic                       out_ready,
    input  wire hsv2rgb_pkg::chan_t         red,
    input  wire hsv2rgb_pkg::chan_t         green,
    input  wire hsv2rgb_pkg::chan_t         blue
);
    import hsv2rgb_pkg::*;

    localparam logic [2:0] STAGES = 3'd4;

    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid & in_ready;
    assign out_acc = out_valid & out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (in_acc & ~out_acc)
            count_next = count_reg + 3'd1;
        else if (out_acc & ~in_acc)
            count_next = count_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 3'd0;
        else
            count_reg <= count_next;
    end

    // an item on the output must have come in
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count_reg != 3'd0)
        else $error("output item with none in flight");

    // never more items held than pipeline slots
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= STAGES)
        else $error("more items in flight than stages");

    // an empty pipeline takes an item
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 3'd0 |-> in_ready)
        else $error("empty pipeline not ready");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
                                    && $stable(blue))
        else $error("stalled output item changed");

endmodule

bind hsv_to_rgb_converter_core hsv2rgb_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (hsv_in.valid),
    .in_ready  (hsv_in.ready),
    .out_valid (rgb_out.valid),
    .out_ready (rgb_out.ready),
    .red       (rgb_out.red),
    .green     (rgb_out.green),
    .blue      (rgb_out.blue)
);

`default_nettype wire
